>>> rtl/cbt_pkg.sv
// Shared types and constants of the configurable byte tokenizer.
// Used by the scanner, the descriptor queue, the emitter and the checker.
package cbt_pkg;

    localparam int POSITION_BITS = 16;
    localparam int KEYWORD_CHARS = 8;
    localparam int KEYWORD_SLOTS = 5;

    localparam int BYTE_BITS      = 8;
    localparam int LEN_BITS       = 16;
    localparam int START_BITS     = 16;
    localparam int KIND_BITS      = 3;
    localparam int MODE_BITS      = 7;
    localparam int REG_BITS       = 64;
    localparam int CFG_INDEX_BITS = 3;
    localparam int QUEUE_DEPTH    = 4;
    localparam int QUEUE_AW       = $clog2(QUEUE_DEPTH);

    localparam logic [LEN_BITS-1:0] LEN_MAX = '1;
    localparam logic [REG_BITS-1:0] KW_MASK = (KEYWORD_CHARS >= 8) ? '1 :
        ((REG_BITS'(1) << (8 * KEYWORD_CHARS)) - REG_BITS'(1));

    // Register indexes.
    localparam logic [CFG_INDEX_BITS-1:0] CFG_MODE   = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SYM_LO = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SYM_HI = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_KW0    = 3'd3;

    // Mode flag bits.
    localparam int MF_IDENT      = 0;
    localparam int MF_INT        = 1;
    localparam int MF_FLOAT      = 2;
    localparam int MF_SPACE      = 3;
    localparam int MF_SKIP_SPACE = 4;
    localparam int MF_STRING     = 5;
    localparam int MF_SKIP_UNREC = 6;

    // Token kinds.
    localparam logic [KIND_BITS-1:0] TOK_UNREC   = 3'd0;
    localparam logic [KIND_BITS-1:0] TOK_IDENT   = 3'd1;
    localparam logic [KIND_BITS-1:0] TOK_KEYWORD = 3'd2;
    localparam logic [KIND_BITS-1:0] TOK_SPACE   = 3'd3;
    localparam logic [KIND_BITS-1:0] TOK_FLOAT   = 3'd4;
    localparam logic [KIND_BITS-1:0] TOK_INT     = 3'd5;
    localparam logic [KIND_BITS-1:0] TOK_SYMBOL  = 3'd6;
    localparam logic [KIND_BITS-1:0] TOK_STRING  = 3'd7;

    localparam logic [BYTE_BITS-1:0] CH_QUOTE     = 8'h22;
    localparam logic [BYTE_BITS-1:0] CH_BACKSLASH = 8'h5C;
    localparam logic [BYTE_BITS-1:0] CH_DOT       = 8'h2E;

    typedef struct packed {
        logic [KIND_BITS-1:0]  token_type;
        logic [START_BITS-1:0] token_start;
        logic [LEN_BITS-1:0]   token_length;
        logic                  unterminated;
        logic                  last_of_run;
    } result_t;

    // One queue entry holds every result caused by one item.
    typedef struct packed {
        logic    two;
        result_t r0;
        result_t r1;
    } entry_t;

    typedef struct packed {
        logic push;
        logic full;
    } push_ctl_t;

endpackage

>>> rtl/cbt_scanner.sv
// Front part of the tokenizer: configuration registers, scan state and classification.
// Puts the one or two descriptors of an item, if any, in a queue entry. Needs cbt_pkg.
module cbt_scanner (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [cbt_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [cbt_pkg::REG_BITS-1:0]         cfg_data,
    input  logic                                 in_valid,
    input  logic [cbt_pkg::BYTE_BITS-1:0]        in_byte,
    input  logic                                 in_end,
    output logic                                 in_ready,
    output cbt_pkg::push_ctl_t                   qctl,
    output cbt_pkg::entry_t                      qdata,
    input  logic                                 qfull
);
    import cbt_pkg::*;

    localparam logic [2:0] PH_IDLE   = 3'd0;
    localparam logic [2:0] PH_IDENT  = 3'd1;
    localparam logic [2:0] PH_NUMBER = 3'd2;
    localparam logic [2:0] PH_STRING = 3'd3;
    localparam logic [2:0] PH_ESCAPE = 3'd4;

    logic [MODE_BITS-1:0]                    mode_reg;
    logic [REG_BITS-1:0]                     sym_lo_reg;
    logic [REG_BITS-1:0]                     sym_hi_reg;
    logic [KEYWORD_SLOTS-1:0][REG_BITS-1:0]  kw_reg;
    logic [KEYWORD_SLOTS-1:0][REG_BITS-1:0]  kw_masked;

    logic [2:0]               phase_reg, phase_next;
    logic [POSITION_BITS-1:0] pos_reg, pos_next;
    logic [POSITION_BITS-1:0] start_reg, start_next;
    logic [LEN_BITS-1:0]      len_reg, len_next, len_grown;
    logic                     dot_reg, dot_next;
    logic [REG_BITS-1:0]      chars_reg, chars_next;

    logic                     accept;
    logic                     consumed;
    logic [1:0]               cnt;
    result_t                  res [2];
    logic                     is_alpha, is_digit, is_alnum, is_space, is_sym;

    function automatic logic [KIND_BITS-1:0] ident_kind(
        input logic [REG_BITS-1:0]                    chars,
        input logic [LEN_BITS-1:0]                    len,
        input logic [KEYWORD_SLOTS-1:0][REG_BITS-1:0] kws
    );
        logic hit;
        hit = 1'b0;
        for (int i = 0; i < KEYWORD_SLOTS; i++)
        begin
            if (kws[i] != '0 && kws[i] == chars)
                hit = 1'b1;
        end
        if (len > LEN_BITS'(KEYWORD_CHARS))
            hit = 1'b0;
        return hit ? TOK_KEYWORD : TOK_IDENT;
    endfunction

    function automatic result_t close_res(
        input logic [2:0]                             phase,
        input logic [POSITION_BITS-1:0]               start,
        input logic [LEN_BITS-1:0]                    len,
        input logic                                   dot,
        input logic [REG_BITS-1:0]                    chars,
        input logic [KEYWORD_SLOTS-1:0][REG_BITS-1:0] kws
    );
        result_t r;
        r = '0;
        r.token_start  = START_BITS'(start);
        r.token_length = len;
        case (phase)
            PH_IDENT:  r.token_type = ident_kind(chars, len, kws);
            PH_NUMBER: r.token_type = dot ? TOK_FLOAT : TOK_INT;
            default:
            begin
                r.token_type   = TOK_STRING;
                r.unterminated = 1'b1;
            end
        endcase
        return r;
    endfunction

    function automatic result_t single(
        input logic [KIND_BITS-1:0]     kind,
        input logic [POSITION_BITS-1:0] start
    );
        result_t r;
        r = '0;
        r.token_type   = kind;
        r.token_start  = START_BITS'(start);
        r.token_length = LEN_BITS'(1);
        return r;
    endfunction

    function automatic logic is_open(input logic [2:0] phase);
        return phase == PH_IDENT || phase == PH_NUMBER ||
               phase == PH_STRING || phase == PH_ESCAPE;
    endfunction

    always_comb
    begin
        for (int i = 0; i < KEYWORD_SLOTS; i++)
            kw_masked[i] = kw_reg[i] & KW_MASK;
    end

    assign in_ready = !qfull;
    assign accept   = in_valid && in_ready;

    assign is_alpha = (in_byte >= 8'h41 && in_byte <= 8'h5A) ||
                      (in_byte >= 8'h61 && in_byte <= 8'h7A);
    assign is_digit = in_byte >= 8'h30 && in_byte <= 8'h39;
    assign is_alnum = is_alpha || is_digit;
    assign is_space = in_byte == 8'h20 || (in_byte >= 8'h09 && in_byte <= 8'h0D);
    assign is_sym   = in_byte[7] ? 1'b0 :
                      in_byte[6] ? sym_hi_reg[in_byte[5:0]] : sym_lo_reg[in_byte[5:0]];
    assign len_grown = (len_reg != LEN_MAX) ? len_reg + LEN_BITS'(1) : len_reg;

    always_comb
    begin
        phase_next = phase_reg;
        start_next = start_reg;
        len_next   = len_reg;
        dot_next   = dot_reg;
        chars_next = chars_reg;
        consumed   = 1'b0;
        cnt        = 2'd0;
        res[0]     = '0;
        res[1]     = '0;

        case (phase_reg)
            PH_IDENT:
            begin
                if (is_alnum)
                begin
                    for (int i = 0; i < KEYWORD_CHARS; i++)
                    begin
                        if (len_reg == LEN_BITS'(i))
                            chars_next[8*i +: 8] = in_byte;
                    end
                    len_next = len_grown;
                    consumed = 1'b1;
                end
                else
                begin
                    res[cnt[0]] = close_res(phase_reg, start_reg, len_reg, dot_reg,
                                            chars_reg, kw_masked);
                    cnt = cnt + 2'd1;
                    phase_next = PH_IDLE;
                end
            end
            PH_NUMBER:
            begin
                if (is_alnum || (in_byte == CH_DOT && mode_reg[MF_FLOAT]))
                begin
                    if (in_byte == CH_DOT)
                        dot_next = 1'b1;
                    len_next = len_grown;
                    consumed = 1'b1;
                end
                else
                begin
                    res[cnt[0]] = close_res(phase_reg, start_reg, len_reg, dot_reg,
                                            chars_reg, kw_masked);
                    cnt = cnt + 2'd1;
                    phase_next = PH_IDLE;
                end
            end
            PH_STRING:
            begin
                len_next = len_grown;
                consumed = 1'b1;
                if (in_byte == CH_BACKSLASH)
                    phase_next = PH_ESCAPE;
                else if (in_byte == CH_QUOTE)
                begin
                    res[cnt[0]] = '0;
                    res[cnt[0]].token_type   = TOK_STRING;
                    res[cnt[0]].token_start  = START_BITS'(start_reg);
                    res[cnt[0]].token_length = len_grown;
                    cnt = cnt + 2'd1;
                    phase_next = PH_IDLE;
                end
            end
            PH_ESCAPE:
            begin
                len_next   = len_grown;
                consumed   = 1'b1;
                phase_next = PH_STRING;
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase

        if (!consumed)
        begin
            start_next = pos_reg;
            len_next   = LEN_BITS'(1);
            if (is_alpha && mode_reg[MF_IDENT])
            begin
                phase_next = PH_IDENT;
                chars_next = REG_BITS'(in_byte);
            end
            else if (is_digit && mode_reg[MF_INT])
            begin
                phase_next = PH_NUMBER;
                dot_next   = 1'b0;
            end
            else if (is_space && mode_reg[MF_SPACE])
            begin
                if (!mode_reg[MF_SKIP_SPACE])
                begin
                    res[cnt[0]] = single(TOK_SPACE, pos_reg);
                    cnt = cnt + 2'd1;
                end
            end
            else if (in_byte == CH_QUOTE && mode_reg[MF_STRING])
            begin
                phase_next = PH_STRING;
            end
            else if (is_sym)
            begin
                res[cnt[0]] = single(TOK_SYMBOL, pos_reg);
                cnt = cnt + 2'd1;
            end
            else if (!mode_reg[MF_SKIP_UNREC])
            begin
                res[cnt[0]] = single(TOK_UNREC, pos_reg);
                cnt = cnt + 2'd1;
            end
        end

        pos_next = pos_reg + POSITION_BITS'(1);

        if (in_end)
        begin
            if (is_open(phase_next))
            begin
                res[cnt[0]] = close_res(phase_next, start_next, len_next, dot_next,
                                        chars_next, kw_masked);
                cnt = cnt + 2'd1;
            end
            phase_next = PH_IDLE;
            pos_next   = '0;
            start_next = '0;
            len_next   = '0;
            dot_next   = 1'b0;
            chars_next = '0;
        end

        if (cnt == 2'd1)
            res[0].last_of_run = 1'b1;
        if (cnt == 2'd2)
            res[1].last_of_run = 1'b1;
    end

    assign qctl.push  = accept && (cnt != 2'd0);
    assign qctl.full  = qfull;
    assign qdata.two  = cnt[1];
    assign qdata.r0   = res[0];
    assign qdata.r1   = res[1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= '0;
            sym_lo_reg <= '0;
            sym_hi_reg <= '0;
            kw_reg     <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_MODE:   mode_reg   <= cfg_data[MODE_BITS-1:0];
                CFG_SYM_LO: sym_lo_reg <= cfg_data;
                CFG_SYM_HI: sym_hi_reg <= cfg_data;
                default:
                begin
                    for (int i = 0; i < KEYWORD_SLOTS; i++)
                    begin
                        if (cfg_index == CFG_KW0 + CFG_INDEX_BITS'(i))
                            kw_reg[i] <= cfg_data;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            pos_reg   <= '0;
            start_reg <= '0;
            len_reg   <= '0;
            dot_reg   <= 1'b0;
            chars_reg <= '0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            start_reg <= start_next;
            len_reg   <= len_next;
            dot_reg   <= dot_next;
            chars_reg <= chars_next;
        end
    end

endmodule

>>> rtl/cbt_queue.sv
// Short queue of descriptor entries between the scanner and the emitter.
// Needs cbt_pkg for the entry type and depth.
module cbt_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  cbt_pkg::push_ctl_t  qctl,
    input  cbt_pkg::entry_t     push_data,
    output logic                full,
    input  logic                pop,
    output cbt_pkg::entry_t     pop_data,
    output logic                empty
);
    import cbt_pkg::*;

    entry_t                entries [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [QUEUE_AW:0]     count_reg, count_next;
    logic                  do_push, do_pop;

    assign full     = count_reg == (QUEUE_AW + 1)'(QUEUE_DEPTH);
    assign empty    = count_reg == '0;
    assign do_push  = qctl.push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = entries[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + (QUEUE_AW + 1)'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - (QUEUE_AW + 1)'(1);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entries[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + QUEUE_AW'(1);
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + QUEUE_AW'(1);
            count_reg <= count_next;
        end
    end

endmodule

>>> rtl/cbt_emitter.sv
// Back part of the tokenizer: unpacks queue entries into single descriptors.
// Holds the output register and the second descriptor of an entry. Needs cbt_pkg.
module cbt_emitter (
    input  logic               clk,
    input  logic               rst_n,
    input  cbt_pkg::entry_t    q_data,
    input  logic               q_empty,
    output logic               q_pop,
    output logic               out_valid,
    input  logic               out_ready,
    output cbt_pkg::result_t   out_res
);
    import cbt_pkg::*;

    logic     out_valid_reg;
    result_t  out_res_reg;
    logic     pend_valid_reg;
    result_t  pend_res_reg;
    logic     can_load;

    assign can_load  = !out_valid_reg || out_ready;
    assign q_pop     = can_load && !pend_valid_reg && !q_empty;
    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else if (can_load)
        begin
            if (pend_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                pend_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg  <= !q_empty;
                pend_valid_reg <= !q_empty && q_data.two;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (can_load)
        begin
            if (pend_valid_reg)
                out_res_reg <= pend_res_reg;
            else if (!q_empty)
            begin
                out_res_reg  <= q_data.r0;
                pend_res_reg <= q_data.r1;
            end
        end
    end

endmodule

>>> rtl/configurable_byte_tokenizer.sv
// Each result is registered in the queue and then in the emitter's output register.
// Throughput: one item per cycle while the queue is not full; the emitter gives one
// result per cycle when not stalled; the four-entry queue absorbs items with two results.
// Reset: rst_n clears the registers, the scan state and the queue at once.
// Top level of the tokenizer: scanner, descriptor queue and emitter. Needs cbt_pkg.
module configurable_byte_tokenizer (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [cbt_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [cbt_pkg::REG_BITS-1:0]       cfg_data,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [7:0]                         s_axis_tdata,  // byte_value
    input  logic                               s_axis_tlast,  // source_end
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [31:0]                        m_axis_tdata,  // token_start, token_length
    output logic [3:0]                         m_axis_tuser,  // token_type, unterminated
    output logic                               m_axis_tlast   // last_of_run
);
    import cbt_pkg::*;

    push_ctl_t qctl;
    entry_t    push_data;
    entry_t    pop_data;
    logic      q_full, q_empty, q_pop;
    result_t   out_res;

    cbt_scanner u_scanner (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (s_axis_tvalid),
        .in_byte   (s_axis_tdata),
        .in_end    (s_axis_tlast),
        .in_ready  (s_axis_tready),
        .qctl      (qctl),
        .qdata     (push_data),
        .qfull     (q_full)
    );

    cbt_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .qctl      (qctl),
        .push_data (push_data),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (pop_data),
        .empty     (q_empty)
    );

    cbt_emitter u_emitter (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_data    (pop_data),
        .q_empty   (q_empty),
        .q_pop     (q_pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_res   (out_res)
    );

    assign m_axis_tdata = {out_res.token_length, out_res.token_start};
    assign m_axis_tuser = {out_res.unterminated, out_res.token_type};
    assign m_axis_tlast = out_res.last_of_run;

endmodule

>>> rtl/cbt_checker.sv
// Port-level checks on the tokenizer's result stream, bound to the top level.
// Needs cbt_pkg and configurable_byte_tokenizer.
module cbt_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [31:0] m_axis_tdata,
    input  logic [3:0]  m_axis_tuser,
    input  logic        m_axis_tlast
);
    import cbt_pkg::*;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) &&
        $stable(m_axis_tuser) && $stable(m_axis_tlast))
        else $error("result changed while stalled");

    a_len: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[31:16] != '0)
        else $error("token of zero length");

    a_unterm_kind: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[3] |-> m_axis_tuser[2:0] == TOK_STRING)
        else $error("unterminated flag on a token that is not a string");

    a_unterm_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[3] |-> m_axis_tlast)
        else $error("unterminated string is not the final result of its item");

endmodule

bind configurable_byte_tokenizer cbt_checker u_cbt_checker (.*);
